// File: hw/rtl/mec_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape counter.
// Used by mec_ctrl, mec_dpath, mandelbrot_escape_count and mec_checker.
`timescale 1ns / 1ps

package mec_pkg;

    localparam int FRAC_BITS = 28;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int CNT_W     = 8;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(100);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam prod_t WORD_MAX = (prod_t'(1) <<< (WORD_W - 1)) - prod_t'(1);
    localparam prod_t WORD_MIN = -(prod_t'(1) <<< (WORD_W - 1));
    localparam prod_t FX_ONE   = prod_t'(1) <<< FRAC_BITS;
    localparam prod_t BOX_RE_LO = -(FX_ONE <<< 1);
    localparam prod_t BOX_RE_HI = FX_ONE;
    localparam prod_t BOX_IM_LO = -FX_ONE;
    localparam prod_t BOX_IM_HI = FX_ONE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic acc_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic esc_now;
        logic last;
    } dp_stat_t;

    function automatic word_t sat_word(input prod_t v);
        word_t r;
        if (v > WORD_MAX)
        begin
            r = word_t'(WORD_MAX);
        end
        else if (v < WORD_MIN)
        begin
            r = word_t'(WORD_MIN);
        end
        else
        begin
            r = word_t'(v);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mec_ctrl.sv
// Controller FSM for the escape counter: handshakes, iteration sequencing,
// iteration limit register. Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  mec_pkg::cnt_t      cfg_data,
    input  logic               pt_valid,
    output logic               pt_stall,
    output logic               res_valid,
    input  logic               res_stall,
    output mec_pkg::cnt_t      limit,
    output mec_pkg::dp_cmd_t   cmd,
    input  mec_pkg::dp_stat_t  stat
);
    import mec_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    cnt_t   limit_reg;
    logic   out_free;

    assign out_free  = !res_valid_reg || !res_stall;
    assign pt_stall  = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign limit     = limit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pt_valid)
                begin
                    state_next = (limit_reg == '0) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = (stat.esc_now || stat.last) ? ST_FIN : ST_MUL;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && pt_valid;
        cmd.mul_en   = (state_reg == ST_MUL);
        cmd.acc_en   = (state_reg == ST_ACC);
        cmd.out_load = (state_reg == ST_FIN) && out_free;
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hw/rtl/mec_dpath.sv
// Datapath for the escape counter: z registers, product registers,
// saturating update, box test, step counter, result register. Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_dpath (
    input  logic               clk,
    input  mec_pkg::dp_cmd_t   cmd,
    input  mec_pkg::word_t     c_real,
    input  mec_pkg::word_t     c_imag,
    input  mec_pkg::cnt_t      limit,
    output mec_pkg::dp_stat_t  stat,
    output mec_pkg::cnt_t      step_count,
    output logic               escaped
);
    import mec_pkg::*;

    word_t cr_reg;
    word_t ci_reg;
    word_t zr_reg;
    word_t zi_reg;
    prod_t prr_reg;
    prod_t pii_reg;
    prod_t pri_reg;
    cnt_t  cnt_reg;
    logic  esc_reg;
    cnt_t  out_cnt_reg;
    logic  out_esc_reg;

    word_t rr;
    word_t ii;
    word_t ri;
    word_t diff;
    word_t nr;
    word_t ni;

    always_comb
    begin
        rr   = sat_word(prr_reg >>> FRAC_BITS);
        ii   = sat_word(pii_reg >>> FRAC_BITS);
        ri   = sat_word(pri_reg >>> (FRAC_BITS - 1));
        diff = sat_word(prod_t'(rr) - prod_t'(ii));
        nr   = sat_word(prod_t'(diff) + prod_t'(cr_reg));
        ni   = sat_word(prod_t'(ri) + prod_t'(ci_reg));
    end

    assign stat.esc_now = (prod_t'(nr) > BOX_RE_HI) || (prod_t'(nr) < BOX_RE_LO) ||
                          (prod_t'(ni) > BOX_IM_HI) || (prod_t'(ni) < BOX_IM_LO);
    assign stat.last    = ((CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(limit);

    assign step_count = out_cnt_reg;
    assign escaped    = out_esc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg  <= c_real;
            ci_reg  <= c_imag;
            zr_reg  <= '0;
            zi_reg  <= '0;
            cnt_reg <= '0;
            esc_reg <= 1'b0;
        end
        if (cmd.mul_en)
        begin
            prr_reg <= prod_t'(zr_reg) * prod_t'(zr_reg);
            pii_reg <= prod_t'(zi_reg) * prod_t'(zi_reg);
            pri_reg <= prod_t'(zr_reg) * prod_t'(zi_reg);
        end
        if (cmd.acc_en)
        begin
            zr_reg <= nr;
            zi_reg <= ni;
            if (stat.esc_now)
            begin
                esc_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + cnt_t'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_cnt_reg <= cnt_reg;
            out_esc_reg <= esc_reg;
        end
    end

endmodule

// File: hw/rtl/mandelbrot_escape_count.sv
// Channel  | Signals                        | Transfer when
// point    | pt_valid, pt_stall, c_real/imag | pt_valid && !pt_stall
// result   | res_valid, res_stall, fields    | res_valid && !res_stall
// config   | cfg_write, cfg_data             | cfg_write
//
// One point runs N iterations, N being at most iteration_limit: each
// iteration is a multiply step on the three 32x32 multipliers followed
// by a saturating add/box-test step.
// Reset sets iteration_limit to 100 and empties the result register.
// A finished result waits in its own register, so the next point is taken
// while res_stall holds it. Depends on mec_pkg, mec_ctrl, mec_dpath.
`timescale 1ns / 1ps

module mandelbrot_escape_count (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  mec_pkg::cnt_t   cfg_data,
    input  logic            pt_valid,
    output logic            pt_stall,
    input  mec_pkg::word_t  c_real,
    input  mec_pkg::word_t  c_imag,
    output logic            res_valid,
    input  logic            res_stall,
    output mec_pkg::cnt_t   step_count,
    output logic            escaped
);
    import mec_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    cnt_t     limit;

    mec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .limit     (limit),
        .cmd       (cmd),
        .stat      (stat)
    );

    mec_dpath u_dpath (
        .clk        (clk),
        .cmd        (cmd),
        .c_real     (c_real),
        .c_imag     (c_imag),
        .limit      (limit),
        .stat       (stat),
        .step_count (step_count),
        .escaped    (escaped)
    );

endmodule

// File: hw/rtl/mec_checker.sv
// Port-level checks for mandelbrot_escape_count, attached by bind.
// Depends on mec_pkg and mandelbrot_escape_count.
`timescale 1ns / 1ps

module mec_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pt_valid,
    input logic            pt_stall,
    input logic            res_valid,
    input logic            res_stall,
    input mec_pkg::cnt_t   step_count,
    input logic            escaped
);
    import mec_pkg::*;

    // a transfer on the point side starts work, so the input closes
    a_busy_after_pt: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_stall |=> pt_stall)
        else $error("point side open right after a transfer");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(step_count) && $stable(escaped))
        else $error("stalled result changed");

    // a new result comes only from a point in progress
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pt_stall))
        else $error("result without a point in progress");

    a_esc_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && escaped |-> step_count != {CNT_W{1'b1}})
        else $error("escape index out of range");

endmodule

bind mandelbrot_escape_count mec_checker u_mec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (pt_valid),
    .pt_stall   (pt_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .step_count (step_count),
    .escaped    (escaped)
);

// File: verif/tb_top.sv
// Self-checking testbench for mandelbrot_escape_count: directed and random points
// under several iteration limits, with random idling on both channels.
// Depends on mec_pkg and the mandelbrot_escape_count RTL.
`timescale 1ns / 1ps

module tb_top;

    import mec_pkg::*;

    typedef struct packed {
        cnt_t steps;
        logic esc;
    } escape_t;

    localparam logic signed [63:0] W_HI   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] W_LO   = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] ONE_64 = 64'sd1 <<< FRAC_BITS;

    localparam word_t FX_P1   = 32'sh1000_0000;
    localparam word_t FX_M1   = 32'shF000_0000;
    localparam word_t FX_M2   = 32'shE000_0000;
    localparam word_t FX_Q    = 32'sh0400_0000;
    localparam word_t FX_Q26  = 32'sh0428_F5C3;
    localparam word_t W_MAX32 = 32'sh7FFF_FFFF;
    localparam word_t W_MIN32 = 32'sh8000_0000;

    localparam int DRAIN_CYCLES = 2 * 255 + 40;

    bit    clk;
    logic  rst_n;
    logic  cfg_write;
    cnt_t  cfg_data;
    logic  pt_valid;
    logic  pt_stall;
    word_t c_real;
    word_t c_imag;
    logic  res_valid;
    logic  res_stall;
    cnt_t  step_count;
    logic  escaped;

    escape_t expected_counts[$];
    escape_t want;
    cnt_t    limit_now;
    bit      failed;
    bit      gaps_on;
    bit      stall_on;

    mandelbrot_escape_count uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .c_real     (c_real),
        .c_imag     (c_imag),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .step_count (step_count),
        .escaped    (escaped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > W_HI)
        begin
            return W_HI;
        end
        else if (v < W_LO)
        begin
            return W_LO;
        end
        return v;
    endfunction

    // z = z*z + c from zero, with the box test on the full fixed-point values
    function automatic escape_t escape_time(input word_t cr, input word_t ci, input cnt_t lim);
        logic signed [63:0] zr, zi, rr, ii, ri, cr64, ci64;
        int      n;
        bit      hit;
        escape_t res;
        cr64 = cr;
        ci64 = ci;
        zr   = 0;
        zi   = 0;
        n    = 0;
        hit  = 0;
        while (!hit && n < int'(lim))
        begin
            rr = clamp32((zr * zr) >>> FRAC_BITS);
            ii = clamp32((zi * zi) >>> FRAC_BITS);
            ri = clamp32((zr * zi) >>> (FRAC_BITS - 1));
            zr = clamp32(clamp32(rr - ii) + cr64);
            zi = clamp32(ri + ci64);
            if (zr > ONE_64 || zr < -(ONE_64 <<< 1) || zi > ONE_64 || zi < -ONE_64)
            begin
                hit = 1;
            end
            else
            begin
                n = n + 1;
            end
        end
        res.steps = cnt_t'(n);
        res.esc   = hit;
        return res;
    endfunction

    function automatic word_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return W_MAX32;
            1: return W_MIN32;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic pick_point(output word_t r, output word_t i);
        int d_re, d_im;
        d_re = int'($urandom_range(0, 8)) - 4;
        d_im = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                r = $urandom;
                i = $urandom;
            end
            2, 3, 4, 5:
            begin
                r = word_t'(int'($urandom_range(0, 805306368)) - 603979776);
                i = word_t'(int'($urandom_range(0, 671088640)) - 335544320);
            end
            6:
            begin
                r = word_t'(int'($urandom_range(0, 134217728)) - 100663296);
                i = word_t'(int'($urandom_range(0, 134217728)) - 67108864);
            end
            7, 8:
            begin
                case ($urandom_range(0, 2))
                    0: r = FX_P1 + d_re;
                    1: r = FX_M2 + d_re;
                    default: r = d_re;
                endcase
                case ($urandom_range(0, 2))
                    0: i = FX_P1 + d_im;
                    1: i = FX_M1 + d_im;
                    default: i = d_im;
                endcase
            end
            default:
            begin
                r = pick_extreme();
                i = pick_extreme();
            end
        endcase
    endtask

    // pt_stall only moves at rising edges, so its value at the falling edge
    // is what the next rising edge sees
    task automatic send_point(input word_t r, input word_t i);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            pt_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        c_real   = r;
        c_imag   = i;
        pt_valid = 1'b1;
        while (pt_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        expected_counts.push_back(escape_time(r, i, limit_now));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pt_valid = 1'b0;
        while (expected_counts.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_limit(input cnt_t v);
        wait_drained();
        cfg_write = 1'b1;
        cfg_data  = v;
        @(negedge clk);
        cfg_write = 1'b0;
        limit_now = v;
    endtask

    // reset limit: box edges, saturation, slow-converging and interior points
    task automatic test_default_points();
        send_point(32'sd0, 32'sd0);
        send_point(W_MAX32, W_MAX32);
        send_point(W_MIN32, W_MIN32);
        send_point(W_MAX32, W_MIN32);
        send_point(W_MIN32, W_MAX32);
        send_point(FX_P1, 32'sd0);
        send_point(FX_M2, 32'sd0);
        send_point(32'sd0, FX_P1);
        send_point(32'sd0, FX_M1);
        send_point(FX_P1 + 32'sd1, 32'sd0);
        send_point(FX_M2 - 32'sd1, 32'sd0);
        send_point(32'sd0, FX_P1 + 32'sd1);
        send_point(32'sd0, FX_M1 - 32'sd1);
        send_point(FX_M1, 32'sd0);
        send_point(FX_Q, 32'sd0);
        send_point(FX_Q26, 32'sd0);
        send_point(32'shE800_0000, 32'sd0);
        send_point(32'shF400_0000, 32'sh0199_999A);
    endtask

    task automatic test_limit_extremes();
        set_limit(8'd0);
        send_point(32'sd0, 32'sd0);
        send_point(W_MAX32, W_MIN32);
        set_limit(8'd1);
        send_point(FX_P1 + 32'sd1, 32'sd0);
        send_point(32'sd0, 32'sd0);
        set_limit(8'd255);
        send_point(32'sd0, 32'sd0);
        send_point(32'shF400_0000, 32'sh0199_999A);
    endtask

    // escape exactly on the last allowed iteration, then one short of it
    task automatic test_last_iteration_escape();
        escape_t probe;
        probe = escape_time(FX_Q26, 32'sd0, 8'd255);
        set_limit(probe.steps + 8'd1);
        send_point(FX_Q26, 32'sd0);
        set_limit(probe.steps);
        send_point(FX_Q26, 32'sd0);
    endtask

    task automatic test_random_phases();
        cnt_t  plan[8];
        word_t r, i;
        plan = '{8'd255, 8'd0, 8'd1, 8'd100, 8'd2, 8'd64, 8'd200, 8'd100};
        plan[4] = cnt_t'($urandom_range(2, 254));
        plan[6] = cnt_t'($urandom_range(2, 254));
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
            begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            set_limit(plan[p]);
            repeat (240)
            begin
                pick_point(r, i);
                send_point(r, i);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        pt_valid  = 1'b0;
        c_real    = '0;
        c_imag    = '0;
        limit_now = LIMIT_RESET;
        failed    = 1'b0;
        gaps_on   = 1'b1;
        stall_on  = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_default_points();
        test_limit_extremes();
        test_last_iteration_escape();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failed)
        begin
            $display("RESULT: ERROR");
        end
        else
        begin
            $display("RESULT: OK");
        end
        $finish;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 30)) @(negedge clk);
            if (stall_on)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                res_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected transfer: step_count=%0d escaped=%0d",
                         $time, step_count, escaped);
                failed = 1'b1;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (step_count !== want.steps)
                begin
                    $display("%0t: step_count expected %0d actual %0d",
                             $time, want.steps, step_count);
                    failed = 1'b1;
                end
                if (escaped !== want.esc)
                begin
                    $display("%0t: escaped expected %0d actual %0d",
                             $time, want.esc, escaped);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
